// ===== hdl/pgf_pkg.sv =====
package pgf_pkg;

  // Reset value of the gain register: G times 10000, scaled by 2^-48
  localparam logic [31:0] GAIN_RESET = 32'd187851900;

  // Register index taken from paddr[2]
  localparam logic ADDR_GAIN = 1'b0;

  // Back pipeline step counts
  localparam int SQRT_STEPS = 33;
  localparam int UDIV_STEPS = 31;
  localparam int UDIV_FIRST = SQRT_STEPS;
  localparam int BACK_STEPS = SQRT_STEPS + UDIV_STEPS;

  // Clamp limits of a 48-bit signed magnitude
  localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

  // One classified pair, front to back
  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][32:0] ad;
    logic [65:0]      s;
    logic [63:0]      n;
  } entry_t;

  // One stage of the back pipeline
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [2:0]       neg;
    logic [65:0]      s;
    logic [34:0]      srem;
    logic [32:0]      root;
    logic [65:0]      mrem;
    logic [63:0]      nq;
    logic [2:0][33:0] urem;
    logic [2:0][30:0] uq;
  } bst_t;

endpackage

// ===== hdl/pgf_front.sv =====
module pgf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        force_gain,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [31:0] src_pos_x,
  input  logic signed [31:0] src_pos_y,
  input  logic signed [31:0] src_pos_z,
  input  logic [31:0]        src_mass,
  input  logic signed [31:0] dst_pos_x,
  input  logic signed [31:0] dst_pos_y,
  input  logic signed [31:0] dst_pos_z,
  input  logic [31:0]        dst_mass,
  output logic               ent_valid,
  output pgf_pkg::entry_t    ent,
  input  logic               ent_full
);

  logic [2:0][32:0] dif;
  logic [2:0][32:0] ad;
  logic [2:0]       neg;
  logic             adv;

  logic             f1_valid;
  logic [2:0][32:0] f1_ad;
  logic [2:0]       f1_neg;
  logic [63:0]      f1_km;
  logic [31:0]      f1_mass;

  logic             f2_valid;
  logic [2:0][32:0] f2_ad;
  logic [2:0]       f2_neg;
  logic [2:0][65:0] f2_sq;
  logic [63:0]      f2_phi;
  logic [63:0]      f2_plo;

  // Form the difference vector and its magnitudes
  always_comb begin
    dif[0] = {dst_pos_x[31], dst_pos_x} - {src_pos_x[31], src_pos_x};
    dif[1] = {dst_pos_y[31], dst_pos_y} - {src_pos_y[31], src_pos_y};
    dif[2] = {dst_pos_z[31], dst_pos_z} - {src_pos_z[31], src_pos_z};
    for (int i = 0; i < 3; i++) begin
      ad[i]  = dif[i][32] ? (33'd0 - dif[i]) : dif[i];
      neg[i] = !dif[i][32] && (dif[i] != 33'd0);
    end
  end

  // Hold both stages while stage two holds an entry and the queue is full
  assign adv        = !(f2_valid && ent_full);
  assign item_stall = f2_valid && ent_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= item_valid;
      f2_valid <= f1_valid;
    end
  end

  // Register differences, gain times source mass, squares and mass products
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_ad   <= ad;
      f1_neg  <= neg;
      f1_km   <= 64'(force_gain) * 64'(src_mass);
      f1_mass <= dst_mass;
      f2_ad   <= f1_ad;
      f2_neg  <= f1_neg;
      for (int i = 0; i < 3; i++) begin
        f2_sq[i] <= 66'(f1_ad[i]) * 66'(f1_ad[i]);
      end
      f2_phi <= 64'(f1_km[63:32]) * 64'(f1_mass);
      f2_plo <= 64'(f1_km[31:0]) * 64'(f1_mass);
    end
  end

  // Sum squares and take the numerator over 2^32
  always_comb begin
    ent.s    = f2_sq[0] + f2_sq[1] + f2_sq[2];
    ent.n    = f2_phi + 64'(f2_plo[63:32]);
    ent.zero = (ent.s == 66'd0);
    ent.neg  = f2_neg;
    ent.ad   = f2_ad;
  end

  assign ent_valid = f2_valid;

endmodule

// ===== hdl/pgf_queue.sv =====
module pgf_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pgf_pkg::entry_t din,
  input  logic            pop,
  output pgf_pkg::entry_t dout,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pgf_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rp];

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

// ===== hdl/pgf_back.sv =====
module pgf_back (
  input  logic               clk,
  input  logic               rst,
  input  pgf_pkg::entry_t    q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z,
  output logic               zero_distance,
  output logic               saturated
);

  localparam int NS = pgf_pkg::BACK_STEPS;

  // One step: a root bit or one direction bit per lane, and a magnitude quotient bit
  function automatic pgf_pkg::bst_t step(pgf_pkg::bst_t a, int k);
    pgf_pkg::bst_t r;
    logic [36:0]   st;
    logic [36:0]   tr;
    logic [66:0]   mt;
    logic [33:0]   ut;
    logic          qb;
    int            i;
    r = a;
    if (k < pgf_pkg::SQRT_STEPS) begin
      st = {a.srem, a.s[2*(pgf_pkg::SQRT_STEPS-1-k) +: 2]};
      tr = {2'b00, a.root, 2'b01};
      if (st >= tr) begin
        r.srem = 35'(st - tr);
        r.root = {a.root[31:0], 1'b1};
      end else begin
        r.srem = st[34:0];
        r.root = {a.root[31:0], 1'b0};
      end
    end
    mt = {a.mrem, a.nq[63]};
    qb = (mt >= {1'b0, a.s});
    r.mrem = qb ? 66'(mt - {1'b0, a.s}) : mt[65:0];
    r.nq   = {a.nq[62:0], qb};
    if (k >= pgf_pkg::UDIV_FIRST) begin
      for (i = 0; i < 3; i++) begin
        ut = (k == pgf_pkg::UDIV_FIRST) ? a.urem[i] : {a.urem[i][32:0], 1'b0};
        qb = (ut >= {1'b0, a.root});
        r.urem[i] = qb ? (ut - {1'b0, a.root}) : ut;
        r.uq[i]   = {a.uq[i][29:0], qb};
      end
    end
    return r;
  endfunction

  pgf_pkg::bst_t    stg [NS+1];
  pgf_pkg::bst_t    load;
  logic             en;

  logic             pr_valid;
  logic             pr_zero;
  logic [2:0]       pr_neg;
  logic [2:0][62:0] pr_lo;
  logic [2:0][62:0] pr_hi;

  logic [2:0][94:0] full_p;
  logic [2:0][64:0] fm;
  logic [2:0][47:0] fv;
  logic [2:0]       fsat;

  // Advance the whole back pipeline unless the result waits
  assign en    = !(result_valid && result_stall);
  assign q_pop = en && !q_empty;

  always_comb begin
    load       = '0;
    load.valid = q_pop;
    load.zero  = q_head.zero;
    load.neg   = q_head.neg;
    load.s     = q_head.s;
    load.nq    = q_head.n;
    for (int i = 0; i < 3; i++) begin
      load.urem[i] = 34'(q_head.ad[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NS; k++) begin
        stg[k].valid <= 1'b0;
      end
      pr_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      stg[0] <= load;
      for (int k = 0; k < NS; k++) begin
        stg[k+1] <= step(stg[k], k);
      end
      pr_valid     <= stg[NS].valid;
      result_valid <= pr_valid;
    end
  end

  // Scale direction by magnitude in two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pr_zero <= stg[NS].zero;
      pr_neg  <= stg[NS].neg;
      for (int i = 0; i < 3; i++) begin
        pr_lo[i] <= 63'(stg[NS].nq[31:0]) * 63'(stg[NS].uq[i]);
        pr_hi[i] <= 63'(stg[NS].nq[63:32]) * 63'(stg[NS].uq[i]);
      end
    end
  end

  // Combine, clamp and apply the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full_p[i] = {pr_hi[i], 32'd0} + 95'(pr_lo[i]);
      fm[i]     = full_p[i][94:30];
      if (fm[i] > 65'(pr_neg[i] ? pgf_pkg::NEG_LIMIT : pgf_pkg::POS_LIMIT)) begin
        fsat[i] = 1'b1;
        fv[i]   = pr_neg[i] ? pgf_pkg::NEG_LIMIT : pgf_pkg::POS_LIMIT;
      end else begin
        fsat[i] = 1'b0;
        fv[i]   = fm[i][47:0];
      end
      if (pr_neg[i]) begin
        fv[i] = 48'd0 - fv[i];
      end
      if (pr_zero) begin
        fv[i]   = 48'd0;
        fsat[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x       <= fv[0];
      force_y       <= fv[1];
      force_z       <= fv[2];
      zero_distance <= pr_zero;
      saturated     <= |fsat;
    end
  end

endmodule

// ===== hdl/pairwise_gravity_force.sv =====
// Pairwise gravity force: one body pair in, the force on the target out.
// Input channel: item_valid / item_stall with the source and target
// positions (signed Q16.16) and masses (unsigned Q16.16); a transfer
// happens at a clock edge with item_valid high and item_stall low.
// Output channel: result_valid / result_stall with force_x/y/z (signed
// Q32.16, clamped), zero_distance and saturated.
// Configuration: APB write of force_gain where paddr[2] is 0; reads there return it.
// Throughput: one pair per cycle while nothing stalls. A pair passes the
// front stages, the queue, the 64-step back pipeline (33 root steps, then
// 31 direction quotient steps, with the 64-bit magnitude quotient
// alongside) and the product stages on its way to result_valid.
// A front part registers the differences and products and drops entries
// into a short queue; the back part drains it.
// Reset clears all valid flags and the queue and loads the default gain.
// While the receiver stalls, the result and the back pipeline hold; the
// front keeps taking pairs until the queue is full, then raises item_stall.
module pairwise_gravity_force #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [31:0] src_pos_x,
  input  logic signed [31:0] src_pos_y,
  input  logic signed [31:0] src_pos_z,
  input  logic [31:0]        src_mass,
  input  logic signed [31:0] dst_pos_x,
  input  logic signed [31:0] dst_pos_y,
  input  logic signed [31:0] dst_pos_z,
  input  logic [31:0]        dst_mass,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z,
  output logic               zero_distance,
  output logic               saturated
);

  logic [31:0]     force_gain;
  logic            ent_valid;
  pgf_pkg::entry_t ent;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  pgf_pkg::entry_t q_head;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pgf_pkg::ADDR_GAIN) ? force_gain : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_gain <= pgf_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == pgf_pkg::ADDR_GAIN)) begin
      force_gain <= pwdata;
    end
  end

  pgf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .force_gain (force_gain),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .src_pos_x  (src_pos_x),
    .src_pos_y  (src_pos_y),
    .src_pos_z  (src_pos_z),
    .src_mass   (src_mass),
    .dst_pos_x  (dst_pos_x),
    .dst_pos_y  (dst_pos_y),
    .dst_pos_z  (dst_pos_z),
    .dst_mass   (dst_mass),
    .ent_valid  (ent_valid),
    .ent        (ent),
    .ent_full   (q_full)
  );

  pgf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (ent_valid && !q_full),
    .din   (ent),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  pgf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .force_x       (force_x),
    .force_y       (force_y),
    .force_z       (force_z),
    .zero_distance (zero_distance),
    .saturated     (saturated)
  );

endmodule

// ===== hdl/pgf_checker.sv =====
module pgf_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [47:0] force_x,
  input logic signed [47:0] force_y,
  input logic signed [47:0] force_z,
  input logic               zero_distance,
  input logic               saturated
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(force_x) && $stable(force_y) && $stable(force_z))
    else $error("stalled result changed");

  // Coincident bodies give zero force and no clamp
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_distance |->
      force_x == 48'sd0 && force_y == 48'sd0 && force_z == 48'sd0 && !saturated)
    else $error("nonzero force at zero distance");

  // A clamp shows as a component at a range limit
  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      force_x == pgf_pkg::POS_LIMIT || force_x == pgf_pkg::NEG_LIMIT ||
      force_y == pgf_pkg::POS_LIMIT || force_y == pgf_pkg::NEG_LIMIT ||
      force_z == pgf_pkg::POS_LIMIT || force_z == pgf_pkg::NEG_LIMIT)
    else $error("saturated without a clamped component");

endmodule

bind pairwise_gravity_force pgf_checker u_checker (.*);
